/* rtl/hpe_pkg.sv */
// Shared types and constants for the Hermite polynomial evaluator.
// Used by hpe_step and hermite_polynomial_eval_core; no dependencies.
package hpe_pkg;

  localparam int unsigned OrderW = 6;
  localparam logic signed [63:0] SatMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SatMin = -64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] OneQ16 = 64'sd65536;

  typedef struct packed {
    logic signed [63:0] prev;
    logic signed [63:0] cur;
    logic signed [15:0] z;
    logic [OrderW-1:0]  n;
    logic               ovf;
  } hpe_term_t;

endpackage

/* rtl/hpe_step.sv */
// One recurrence step H(K) = 2z*H(K-1) - 2(K-1)*H(K-2), split over three register stages.
// Depends on hpe_pkg. Items with an order below K pass through unchanged.
module hpe_step #(
  parameter int unsigned K = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  hpe_pkg::hpe_term_t term_i,
  output logic              valid_o,
  output hpe_pkg::hpe_term_t term_o
);
  import hpe_pkg::*;

  localparam logic [63:0] Mul = 64'(2 * (K - 1));
  localparam logic [63:0] Lim = 64'h7FFF_FFFF_FFFF_FFFF / Mul;
  localparam logic [7:0]  Mul8 = Mul[7:0];

  // Stage 1: partial products of the point scaling and the count product.
  logic        v1_q;
  hpe_term_t   t1_q;
  logic        act1_q, neg1_q, bpos1_q, bneg1_q;
  logic [47:0] hi1_q, lo1_q;
  logic signed [63:0] bprod1_q;

  logic [63:0] mh;
  logic [15:0] mz;
  logic signed [71:0] bfull;

  always_comb begin
    mh    = term_i.cur[63] ? 64'(-term_i.cur) : 64'(term_i.cur);
    mz    = term_i.z[15] ? 16'(-term_i.z) : 16'(term_i.z);
    bfull = term_i.prev * $signed({1'b0, Mul8});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q     <= term_i;
      act1_q   <= (32'(term_i.n) >= K);
      neg1_q   <= term_i.cur[63] ^ term_i.z[15];
      hi1_q    <= mh[63:32] * mz;
      lo1_q    <= mh[31:0] * mz;
      bpos1_q  <= term_i.prev > $signed(Lim);
      bneg1_q  <= term_i.prev < -$signed(Lim);
      bprod1_q <= bfull[63:0];
    end
  end

  // Stage 2: finish both products with saturation.
  logic        v2_q;
  hpe_term_t   t2_q;
  logic        act2_q;
  logic signed [63:0] a2_q, b2_q;

  logic [63:0] mag;
  logic        asat;
  logic signed [63:0] a_d, b_d;
  hpe_term_t   t2_d;

  always_comb begin
    mag  = {hi1_q[42:0], 21'd0} + 64'((49'(lo1_q) + 49'd1024) >> 11);
    asat = (hi1_q >= 48'h400_0000_0000) || mag[63];
    if (asat) begin
      a_d = neg1_q ? SatMin : SatMax;
    end else begin
      a_d = neg1_q ? -$signed(mag) : $signed(mag);
    end
    if (bpos1_q) begin
      b_d = SatMax;
    end else if (bneg1_q) begin
      b_d = SatMin;
    end else begin
      b_d = bprod1_q;
    end
    t2_d     = t1_q;
    t2_d.ovf = t1_q.ovf | (act1_q & (asat | bpos1_q | bneg1_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q     <= t2_d;
      act2_q   <= act1_q;
      a2_q     <= a_d;
      b2_q     <= b_d;
    end
  end

  // Stage 3: saturating difference and shift of the term window.
  logic signed [64:0] diff;
  logic signed [63:0] next;
  logic               dsat;
  hpe_term_t          t3_d;

  always_comb begin
    diff = {a2_q[63], a2_q} - {b2_q[63], b2_q};
    dsat = (diff > 65'sh0_7FFF_FFFF_FFFF_FFFF) || (diff < -65'sh0_7FFF_FFFF_FFFF_FFFF);
    if (dsat) begin
      next = diff[64] ? SatMin : SatMax;
    end else begin
      next = diff[63:0];
    end
    t3_d = t2_q;
    if (act2_q) begin
      t3_d.prev = t2_q.cur;
      t3_d.cur  = next;
      t3_d.ovf  = t2_q.ovf | dsat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_o <= t3_d;
    end
  end

endmodule

/* rtl/hermite_polynomial_eval_core.sv */
// Physicists' Hermite polynomial evaluator, one recurrence step per three pipeline stages.
// Every order takes the same path through the input register, all step stages and the output register;
// one transaction enters per cycle while the pipeline is not stalled.
// The whole pipeline advances together, so it stalls only while the output waits.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers are not reset.
// Depends on hpe_pkg and hpe_step.
module hermite_polynomial_eval_core #(
  parameter int unsigned MAX_ORDER = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         order_i,
  input  logic signed [15:0] point_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] value_o,
  output logic               overflow_o
);
  import hpe_pkg::*;

  localparam int unsigned Steps = (MAX_ORDER > 1) ? MAX_ORDER - 1 : 0;

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic      vld [Steps+1];
  hpe_term_t trm [Steps+1];

  logic [OrderW-1:0] n_clamp;
  assign n_clamp = (32'(order_i) > MAX_ORDER) ? OrderW'(MAX_ORDER) : OrderW'(order_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      trm[0].prev <= OneQ16;
      trm[0].cur  <= 64'(point_i) * 64'sd32;
      trm[0].z    <= point_i;
      trm[0].n    <= n_clamp;
      trm[0].ovf  <= 1'b0;
    end
  end

  for (genvar g = 0; g < Steps; g++) begin : g_step
    hpe_step #(.K(g + 2)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(vld[g]),
      .term_i (trm[g]),
      .valid_o(vld[g+1]),
      .term_o (trm[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vld[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_o    <= (trm[Steps].n == '0) ? OneQ16 : trm[Steps].cur;
      overflow_o <= (trm[Steps].n != '0) && trm[Steps].ovf;
    end
  end

endmodule
